// ----- design/tlex_pkg.sv -----
// ----------------------------------------------------------------------------
// tlex_pkg: shared types and constants for the streaming lexer
// Token kinds, result record and sizing of position, length and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tlex_pkg;

    localparam int POS_W     = 16;  // internal line/column counters, 8..32
    localparam int LEN_W     = 8;   // internal run length counter, 4..16
    localparam int RES_DEPTH = 4;   // result queue entries, power of two
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic [4:0] {
        KIND_IDENT   = 5'd0,
        KIND_INT     = 5'd1,
        KIND_FN      = 5'd2,
        KIND_RETURN  = 5'd3,
        KIND_INTEGER = 5'd4,
        KIND_PLUS    = 5'd5,
        KIND_MINUS   = 5'd6,
        KIND_ARROW   = 5'd7,
        KIND_EQUALS  = 5'd8,
        KIND_LPAREN  = 5'd9,
        KIND_RPAREN  = 5'd10,
        KIND_LBRACE  = 5'd11,
        KIND_RBRACE  = 5'd12,
        KIND_SEMI    = 5'd13,
        KIND_COMMA   = 5'd14,
        KIND_INVALID = 5'd15,
        KIND_EOF     = 5'd16
    } kind_t;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_IDENT   = 4'b0010,
        MODE_INTEGER = 4'b0100,
        MODE_MINUS   = 4'b1000
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  length;
        logic [7:0]  bad;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ----- design/token_lexer_stream_unit.sv -----
// ----------------------------------------------------------------------------
// token_lexer_stream_unit: streaming source lexer
// Classifies one byte per cycle and emits tokens with start position and length.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one transaction per source byte in
//   char_code, or an end marker with end_of_text set. A zero byte also ends
//   the text. Output channel (out_valid / out_stall): one transaction per
//   token, with kind, start line/column, length, offending byte for invalid
//   tokens, and last_of_run on the final token caused by an input byte.
//   Order: a byte is registered on accept, lexed once the queue has room, and
//   its tokens are then written to the result queue that feeds the output.
//   Throughput: one byte per cycle. A byte produces at most two tokens; the
//   four-entry result queue lets lexing continue while up to two tokens wait,
//   so the rate drops below one byte per cycle only while the receiver stalls
//   or the queue drains a two-token burst.
//   Stall: in_stall rises when the queue has fewer than two free entries and
//   a byte is waiting; queued tokens stay stable until taken.
//   Reset: lexer returns to idle at line 1, column 1, queue empty. After an
//   end-of-file token the lexer also returns to idle at line 1, column 1.
// ----------------------------------------------------------------------------
`default_nettype none

module token_lexer_stream_unit
    import tlex_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       token_kind,
    output logic [15:0]      start_line,
    output logic [15:0]      start_column,
    output logic [7:0]       token_length,
    output logic [7:0]       invalid_byte,
    output logic             last_of_run
);

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // keyword spelling by character index
    function automatic logic [7:0] kw_int_char(input logic [LEN_W-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            LEN_W'(0): ch = 8'h69;  // i
            LEN_W'(1): ch = 8'h6E;  // n
            LEN_W'(2): ch = 8'h74;  // t
            default:   ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] kw_fn_char(input logic [LEN_W-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            LEN_W'(0): ch = 8'h66;  // f
            LEN_W'(1): ch = 8'h6E;  // n
            default:   ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] kw_ret_char(input logic [LEN_W-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            LEN_W'(0): ch = 8'h72;  // r
            LEN_W'(1): ch = 8'h65;  // e
            LEN_W'(2): ch = 8'h74;  // t
            LEN_W'(3): ch = 8'h75;  // u
            LEN_W'(4): ch = 8'h72;  // r
            LEN_W'(5): ch = 8'h6E;  // n
            default:   ch = 8'h00;
        endcase
        return ch;
    endfunction

    // zero never matches: end bytes never reach the keyword check
    function automatic logic [2:0] kw_check(input logic [2:0] alive,
                                            input logic [LEN_W-1:0] idx,
                                            input logic [7:0] ch);
        logic [2:0] res;
        res[0] = alive[0] && (kw_int_char(idx) == ch);
        res[1] = alive[1] && (kw_fn_char(idx) == ch);
        res[2] = alive[2] && (kw_ret_char(idx) == ch);
        return res;
    endfunction

    function automatic kind_t ident_kind(input logic [2:0] alive,
                                         input logic [LEN_W-1:0] len);
        kind_t k;
        priority if (alive[0] && len == LEN_W'(3)) k = KIND_INT;
        else if (alive[1] && len == LEN_W'(2))     k = KIND_FN;
        else if (alive[2] && len == LEN_W'(6))     k = KIND_RETURN;
        else                                       k = KIND_IDENT;
        return k;
    endfunction

    function automatic logic [15:0] pos_out(input logic [POS_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'd65535) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [7:0] len_out(input logic [LEN_W-1:0] v);
        logic [15:0] w;
        w = 16'(v);
        return (w > 16'd255) ? 8'hFF : w[7:0];
    endfunction

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       end_reg;

    // lexer state
    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] cur_line_reg, cur_line_next;
    logic [POS_W-1:0] cur_col_reg, cur_col_next;
    logic [POS_W-1:0] tok_line_reg, tok_line_next;
    logic [POS_W-1:0] tok_col_reg, tok_col_next;
    logic [LEN_W-1:0] run_reg, run_next;
    logic [2:0]       alive_reg, alive_next;

    // result queue
    result_t                fifo_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]   count_reg, count_next;

    logic             commit, accept, pop;
    logic             is_end, is_alpha, is_digit, is_word, is_space;
    logic [POS_W-1:0] adv_line, adv_col;
    logic [LEN_W-1:0] run_inc;
    logic             pend_emit, sec_emit, done;
    result_t          pend_res, sec_res, first_res, second_res;
    logic [1:0]       push_n;

    assign commit   = in_valid_reg && (count_reg <= RES_CNT_W'(RES_DEPTH - 2));
    assign in_stall = in_valid_reg && !commit;
    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    assign is_end   = end_reg || (char_reg == 8'h00);
    assign is_alpha = (char_reg >= 8'h61 && char_reg <= 8'h7A) ||
                      (char_reg >= 8'h41 && char_reg <= 8'h5A);
    assign is_digit = (char_reg >= 8'h30 && char_reg <= 8'h39);
    assign is_word  = is_alpha || is_digit || (char_reg == CH_UNDER);
    assign is_space = (char_reg == CH_SPACE) || (char_reg >= 8'h09 && char_reg <= 8'h0D);

    // position after consuming the current byte
    always_comb
    begin
        if (char_reg == CH_NL)
        begin
            adv_line = (cur_line_reg < POS_MAX) ? cur_line_reg + POS_ONE : cur_line_reg;
            adv_col  = POS_ONE;
        end
        else
        begin
            adv_line = cur_line_reg;
            adv_col  = (cur_col_reg < POS_MAX) ? cur_col_reg + POS_ONE : cur_col_reg;
        end
    end

    assign run_inc = (run_reg < LEN_MAX) ? run_reg + LEN_W'(1) : run_reg;

    always_comb
    begin
        mode_next     = mode_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        run_next      = run_reg;
        alive_next    = alive_reg;
        pend_emit     = 1'b0;
        sec_emit      = 1'b0;
        done          = 1'b0;

        pend_res        = '0;
        pend_res.kind   = KIND_IDENT;
        pend_res.line   = pos_out(tok_line_reg);
        pend_res.column = pos_out(tok_col_reg);
        pend_res.length = len_out(run_reg);

        sec_res         = '0;
        sec_res.kind    = KIND_INVALID;
        sec_res.line    = pos_out(cur_line_reg);
        sec_res.column  = pos_out(cur_col_reg);
        sec_res.length  = 8'd1;

        if (commit)
        begin
            // close or extend the pending token
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (!is_end && is_word)
                    begin
                        alive_next    = kw_check(alive_reg, run_reg, char_reg);
                        run_next      = run_inc;
                        cur_line_next = adv_line;
                        cur_col_next  = adv_col;
                        done          = 1'b1;
                    end
                    else
                    begin
                        pend_emit     = 1'b1;
                        pend_res.kind = ident_kind(alive_reg, run_reg);
                        mode_next     = MODE_IDLE;
                    end
                end
                MODE_INTEGER:
                begin
                    if (!is_end && is_digit)
                    begin
                        run_next      = run_inc;
                        cur_line_next = adv_line;
                        cur_col_next  = adv_col;
                        done          = 1'b1;
                    end
                    else
                    begin
                        pend_emit     = 1'b1;
                        pend_res.kind = KIND_INTEGER;
                        mode_next     = MODE_IDLE;
                    end
                end
                MODE_MINUS:
                begin
                    mode_next = MODE_IDLE;
                    pend_emit = 1'b1;
                    if (!is_end && char_reg == CH_GT)
                    begin
                        pend_res.kind   = KIND_ARROW;
                        pend_res.length = len_out(LEN_W'(2));
                        cur_line_next   = adv_line;
                        cur_col_next    = adv_col;
                        done            = 1'b1;
                    end
                    else
                    begin
                        pend_res.kind   = KIND_MINUS;
                        pend_res.length = len_out(LEN_W'(1));
                    end
                end
                default: ;
            endcase

            // lex the byte itself
            if (!done)
            begin
                priority if (is_end)
                begin
                    sec_emit       = 1'b1;
                    sec_res.kind   = KIND_EOF;
                    sec_res.length = 8'd0;
                    mode_next      = MODE_IDLE;
                    cur_line_next  = POS_ONE;
                    cur_col_next   = POS_ONE;
                    tok_line_next  = POS_ONE;
                    tok_col_next   = POS_ONE;
                    run_next       = '0;
                    alive_next     = 3'b111;
                end
                else if (is_space)
                begin
                    cur_line_next = adv_line;
                    cur_col_next  = adv_col;
                end
                else if (is_alpha || char_reg == CH_UNDER || is_digit || char_reg == CH_MINUS)
                begin
                    if (is_digit)
                    begin
                        mode_next  = MODE_INTEGER;
                        alive_next = 3'b111;
                    end
                    else if (char_reg == CH_MINUS)
                    begin
                        mode_next  = MODE_MINUS;
                        alive_next = 3'b111;
                    end
                    else
                    begin
                        mode_next  = MODE_IDENT;
                        alive_next = kw_check(3'b111, '0, char_reg);
                    end
                    tok_line_next = cur_line_reg;
                    tok_col_next  = cur_col_reg;
                    run_next      = LEN_W'(1);
                    cur_line_next = adv_line;
                    cur_col_next  = adv_col;
                end
                else
                begin
                    sec_emit = 1'b1;
                    unique case (char_reg)
                        CH_PLUS:  sec_res.kind = KIND_PLUS;
                        CH_EQ:    sec_res.kind = KIND_EQUALS;
                        CH_LPAR:  sec_res.kind = KIND_LPAREN;
                        CH_RPAR:  sec_res.kind = KIND_RPAREN;
                        CH_LBRC:  sec_res.kind = KIND_LBRACE;
                        CH_RBRC:  sec_res.kind = KIND_RBRACE;
                        CH_SEMI:  sec_res.kind = KIND_SEMI;
                        CH_COMMA: sec_res.kind = KIND_COMMA;
                        default:
                        begin
                            sec_res.kind = KIND_INVALID;
                            sec_res.bad  = char_reg;
                        end
                    endcase
                    cur_line_next = adv_line;
                    cur_col_next  = adv_col;
                end
            end
        end
    end

    always_comb
    begin
        push_n          = {1'b0, pend_emit} + {1'b0, sec_emit};
        first_res       = pend_emit ? pend_res : sec_res;
        first_res.last  = !(pend_emit && sec_emit);
        second_res      = sec_res;
        second_res.last = 1'b1;
        wr_ptr_next     = wr_ptr_reg + RES_PTR_W'(push_n);
        rd_ptr_next     = rd_ptr_reg + RES_PTR_W'(pop);
        count_next      = count_reg + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
        in_valid_next   = accept ? 1'b1 : (commit ? 1'b0 : in_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            cur_line_reg <= POS_ONE;
            cur_col_reg  <= POS_ONE;
            tok_line_reg <= POS_ONE;
            tok_col_reg  <= POS_ONE;
            run_reg      <= '0;
            alive_reg    <= 3'b111;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            mode_reg     <= mode_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            run_reg      <= run_next;
            alive_reg    <= alive_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_code;
            end_reg  <= end_of_text;
        end
        if (push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= first_res;
        end
        if (push_n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + RES_PTR_W'(1)] <= second_res;
        end
    end

    assign out_valid    = (count_reg != '0);
    assign token_kind   = fifo_reg[rd_ptr_reg].kind;
    assign start_line   = fifo_reg[rd_ptr_reg].line;
    assign start_column = fifo_reg[rd_ptr_reg].column;
    assign token_length = fifo_reg[rd_ptr_reg].length;
    assign invalid_byte = fifo_reg[rd_ptr_reg].bad;
    assign last_of_run  = fifo_reg[rd_ptr_reg].last;

endmodule

`default_nettype wire

// ----- design/tlex_checker.sv -----
// ----------------------------------------------------------------------------
// tlex_checker: port-level checks for the streaming lexer
// Output handshake rules and consistency of emitted token records.
// ----------------------------------------------------------------------------
`default_nettype none

module tlex_checker
    import tlex_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [4:0]  token_kind,
    input wire logic [15:0] start_line,
    input wire logic [15:0] start_column,
    input wire logic [7:0]  token_length,
    input wire logic [7:0]  invalid_byte,
    input wire logic        last_of_run
);

    // a stalled output transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    // a stalled token's kind, position, length and last flag do not change
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(token_kind) && $stable(start_line) &&
            $stable(start_column) && $stable(token_length) && $stable(last_of_run))
        else $error("output record changed while stalled");

    // end of file closes a run and carries no characters
    a_eof_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_EOF |-> token_length == 8'd0 && last_of_run)
        else $error("malformed end-of-file token");

    // only invalid tokens report an offending byte
    a_bad_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != KIND_INVALID |-> invalid_byte == 8'd0)
        else $error("offending byte on a valid token");

    // an arrow is two characters and always the last token of its byte
    a_arrow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_ARROW |->
            token_length == 8'd2 && last_of_run && start_line != 16'd0)
        else $error("malformed arrow token");

endmodule

bind token_lexer_stream_unit tlex_checker u_tlex_checker (.*);

`default_nettype wire

// ----- bench/token_lexer_stream_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// token_lexer_stream_unit_tb: self-checking bench for the streaming lexer
// Feeds source bytes and end markers through the valid/stall input channel.
// A local lexer computes the expected tokens for each accepted byte. A
// checker compares every token taken from the output channel, in order,
// against that queue. Directed tests run first, including a long output hold,
// then random token streams under several sender idle / receiver stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module token_lexer_stream_unit_tb;

    import tlex_pkg::*;

    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int TAIL_CYCLES    = 6;
    localparam logic [POS_W-1:0] POS_TOP = '1;
    localparam logic [LEN_W-1:0] LEN_TOP = '1;
    localparam logic [8*9-1:0]   SYMBOLS = "+=(){};,-";

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_code;
    logic        end_of_text;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [7:0]  token_length;
    logic [7:0]  invalid_byte;
    logic        last_of_run;

    // stimulus knobs
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int items_sent;
    int mismatches;
    int timeout_count;

    // local lexer state
    mode_t            scan_state;
    logic [POS_W-1:0] cur_line;
    logic [POS_W-1:0] cur_col;
    logic [POS_W-1:0] tok_line;
    logic [POS_W-1:0] tok_col;
    logic [LEN_W-1:0] run_len;
    logic [2:0]       kw_live;

    result_t pending_tokens [$];

    token_lexer_stream_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .start_line   (start_line),
        .start_column (start_column),
        .token_length (token_length),
        .invalid_byte (invalid_byte),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Local lexer
    // ------------------------------------------------------------------
    function automatic int kw_len(input int k);
        case (k)
            0:       return 3;
            1:       return 2;
            default: return 6;
        endcase
    endfunction

    function automatic logic [7:0] kw_char(input int k, input int i);
        logic [47:0] txt;
        case (k)
            0:       txt = {"int", 24'h0};
            1:       txt = {"fn", 32'h0};
            default: txt = "return";
        endcase
        return txt[47 - 8*i -: 8];
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [15:0] clip16(input logic [31:0] v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic result_t make_token(input kind_t k, input logic [POS_W-1:0] ln,
                                           input logic [POS_W-1:0] col,
                                           input logic [15:0] len, input logic [7:0] bad);
        result_t t;
        t.kind   = k;
        t.line   = clip16(32'(ln));
        t.column = clip16(32'(col));
        t.length = (len > 16'd255) ? 8'hFF : len[7:0];
        t.bad    = bad;
        t.last   = 1'b0;
        return t;
    endfunction

    // append one expected token at the tail of the queue
    function automatic void queue_token(input result_t t);
        pending_tokens.insert(pending_tokens.size(), t);
    endfunction

    function automatic void reset_lexer();
        scan_state = MODE_IDLE;
        cur_line   = POS_W'(1);
        cur_col    = POS_W'(1);
        tok_line   = POS_W'(1);
        tok_col    = POS_W'(1);
        run_len    = '0;
        kw_live    = 3'b111;
    endfunction

    function automatic void kw_step(input logic [7:0] c);
        for (int k = 0; k < 3; k++)
            if (int'(run_len) >= kw_len(k) || kw_char(k, int'(run_len)) != c)
                kw_live[k] = 1'b0;
    endfunction

    function automatic void grow_run();
        if (run_len != LEN_TOP)
            run_len = run_len + LEN_W'(1);
    endfunction

    function automatic void advance(input logic [7:0] c);
        if (c == 8'h0A)
        begin
            if (cur_line != POS_TOP)
                cur_line = cur_line + POS_W'(1);
            cur_col = POS_W'(1);
        end
        else if (cur_col != POS_TOP)
        begin
            cur_col = cur_col + POS_W'(1);
        end
    endfunction

    function automatic kind_t word_kind();
        for (int k = 0; k < 3; k++)
            if (kw_live[k] && int'(run_len) == kw_len(k))
                return kind_t'(k + 1);
        return KIND_IDENT;
    endfunction

    function automatic void open_run(input mode_t m);
        scan_state = m;
        tok_line   = cur_line;
        tok_col    = cur_col;
        run_len    = '0;
        kw_live    = 3'b111;
    endfunction

    // Lex one accepted transaction and queue the tokens it produces.
    function automatic void lex_byte(input logic [7:0] c, input logic eot);
        result_t burst [2];
        int      n;
        bit      stop;
        kind_t   k;
        logic [7:0] bad;
        n    = 0;
        stop = eot || (c == 8'h00);

        case (scan_state)
            MODE_IDENT:
            begin
                if (!stop && is_word(c))
                begin
                    kw_step(c);
                    grow_run();
                    advance(c);
                    return;
                end
                burst[n] = make_token(word_kind(), tok_line, tok_col, 16'(run_len), 8'h00);
                n = n + 1;
                scan_state = MODE_IDLE;
            end
            MODE_INTEGER:
            begin
                if (!stop && is_digit(c))
                begin
                    grow_run();
                    advance(c);
                    return;
                end
                burst[n] = make_token(KIND_INTEGER, tok_line, tok_col, 16'(run_len), 8'h00);
                n = n + 1;
                scan_state = MODE_IDLE;
            end
            MODE_MINUS:
            begin
                scan_state = MODE_IDLE;
                if (!stop && c == ">")
                begin
                    burst[0]      = make_token(KIND_ARROW, tok_line, tok_col, 16'd2, 8'h00);
                    burst[0].last = 1'b1;
                    advance(c);
                    queue_token(burst[0]);
                    return;
                end
                burst[n] = make_token(KIND_MINUS, tok_line, tok_col, 16'd1, 8'h00);
                n = n + 1;
            end
            default:
            begin
            end
        endcase

        if (stop)
        begin
            burst[n] = make_token(KIND_EOF, cur_line, cur_col, 16'd0, 8'h00);
            n = n + 1;
            reset_lexer();
        end
        else if (is_space(c))
        begin
            advance(c);
        end
        else if (is_alpha(c) || c == "_")
        begin
            open_run(MODE_IDENT);
            kw_step(c);
            grow_run();
            advance(c);
        end
        else if (is_digit(c))
        begin
            open_run(MODE_INTEGER);
            grow_run();
            advance(c);
        end
        else if (c == "-")
        begin
            open_run(MODE_MINUS);
            grow_run();
            advance(c);
        end
        else
        begin
            bad = 8'h00;
            case (c)
                "+":     k = KIND_PLUS;
                "=":     k = KIND_EQUALS;
                "(":     k = KIND_LPAREN;
                ")":     k = KIND_RPAREN;
                "{":     k = KIND_LBRACE;
                "}":     k = KIND_RBRACE;
                ";":     k = KIND_SEMI;
                ",":     k = KIND_COMMA;
                default:
                begin
                    k   = KIND_INVALID;
                    bad = c;
                end
            endcase
            burst[n] = make_token(k, cur_line, cur_col, 16'd1, bad);
            n = n + 1;
            advance(c);
        end

        if (n > 0)
            burst[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            queue_token(burst[i]);
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall, plus a long hold on request
    // ------------------------------------------------------------------
    initial
    begin : recv_side
        int hold_len;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_len = hold_req;
                hold_req = 0;
                repeat (hold_len)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_tokens
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tokens.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected token kind=%0d line=%0d col=%0d len=%0d",
                             $realtime, token_kind, start_line, start_column, token_length);
                mismatches++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (token_kind !== want.kind || start_line !== want.line ||
                    start_column !== want.column || token_length !== want.length ||
                    invalid_byte !== want.bad || last_of_run !== want.last)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: token mismatch", $realtime);
                        $display("  expected kind=%0d line=%0d col=%0d len=%0d bad=%h last=%b",
                                 want.kind, want.line, want.column, want.length,
                                 want.bad, want.last);
                        $display("  actual   kind=%0d line=%0d col=%0d len=%0d bad=%h last=%b",
                                 token_kind, start_line, start_column, token_length,
                                 invalid_byte, last_of_run);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        for (timeout_count = 0; timeout_count < TIMEOUT_CYCLES; timeout_count++)
            @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] c, input logic eot);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        char_code   <= c;
        end_of_text <= eot;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        lex_byte(c, eot);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // Drop valid and wait until every expected token is out, plus the pipe tail.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] word_char(input int i);
        if (i < 26)
            return 8'("a" + i);
        else if (i < 52)
            return 8'("A" + i - 26);
        else if (i < 62)
            return 8'("0" + i - 52);
        return "_";
    endfunction

    task automatic random_lexeme();
        int k;
        int n;
        case ($urandom_range(0, 11))
            0, 1:
            begin
                // keyword, sometimes cut short or extended
                k = $urandom_range(0, 2);
                n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, kw_len(k)) : kw_len(k);
                for (int i = 0; i < n; i++)
                    send_item(kw_char(k, i), 1'b0);
                if ($urandom_range(0, 3) == 0)
                    send_item(word_char($urandom_range(0, 62)), 1'b0);
            end
            2, 3:
            begin
                k = $urandom_range(0, 52);
                send_item((k == 52) ? 8'("_") : word_char(k), 1'b0);
                n = $urandom_range(0, 7);
                for (int i = 0; i < n; i++)
                    send_item(word_char($urandom_range(0, 62)), 1'b0);
            end
            4:
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_item(word_char($urandom_range(52, 61)), 1'b0);
            end
            5, 6:
            begin
                k = $urandom_range(0, 8);
                send_item(SYMBOLS[8*(8-k) +: 8], 1'b0);
            end
            7, 8:
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    send_item(($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : 8'(" "),
                              1'b0);
            end
            9:
            begin
                send_item("-", 1'b0);
                if ($urandom_range(0, 1) == 0)
                    send_item(">", 1'b0);
            end
            10:
                send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(8'h00, 1'b0);
                else
                    send_item(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_keywords();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_text("int fn return in_");
        send_item(8'hA5, 1'b1);     // end marker with a nonzero byte
        drain();
    endtask

    task automatic test_symbols();
        send_text("x;->-+=(){},-");
        send_item(8'h00, 1'b0);     // NUL flushes the pending minus
        drain();
    endtask

    task automatic test_numbers_and_invalid();
        send_text("42a 9\t\n#");
        send_item(8'h80, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("7");
        send_item(8'h00, 1'b1);
        drain();
    endtask

    task automatic test_length_saturation();
        send_text("return");
        repeat (254) send_item("z", 1'b0);
        send_text(";");
        repeat (260) send_item("9", 1'b0);
        send_item(8'h00, 1'b1);
        drain();
    endtask

    // Column and line tracking across spaces, tabs and newlines.
    task automatic test_position_tracking();
        repeat (12) send_item(" ", 1'b0);
        send_text("xy");
        repeat (4) send_item(8'h0A, 1'b0);
        send_text("\t+");
        send_item(8'h00, 1'b1);
        drain();
    endtask

    // Hold the output long enough for the queue to fill and stall the input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 400;
        repeat (20) send_text("x;+");
        drain();
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct, input int count);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = items_sent + count;
        while (items_sent < stop_at)
            random_lexeme();
        drain();
    endtask

    task automatic test_random_phases();
        run_random(0, 0, 150);
        run_random(84, 0, 150);
        run_random(0, 84, 150);
        run_random(20, 20, 150);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        char_code      = 8'h00;
        end_of_text    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        items_sent     = 0;
        mismatches     = 0;
        reset_lexer();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_keywords();
        test_symbols();
        test_numbers_and_invalid();
        test_length_saturation();
        test_position_tracking();
        test_backpressure();
        test_random_phases();

        drain();
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
design/tlex_pkg.sv
design/token_lexer_stream_unit.sv
design/tlex_checker.sv
bench/token_lexer_stream_unit_tb.sv
